// ----- hdl/lfzc_pkg.sv -----
// Shared types, constants and sine table functions for the front-zone obstacle check.
package lfzc_pkg;

	localparam int SINE_TABLE_DEPTH_DEF = 256;
	localparam int RANGE_BITS_DEF       = 16;
	localparam int QUEUE_DEPTH          = 4;
	localparam int ADDR_BITS            = 5;
	localparam int FIELD_BITS           = 16;

	// register reset values
	localparam logic [15:0] ANGLE_START_RST   = 16'd0;
	localparam logic [15:0] ANGLE_STEP_RST    = 16'd182;
	localparam logic [15:0] SECTOR_EDGE_RST   = 16'd8532;
	localparam logic [15:0] HALF_WIDTH_RST    = 16'd150;
	localparam logic [15:0] ZONE_NEAR_RST     = 16'd141;
	localparam logic [15:0] ZONE_FAR_RST      = 16'd341;
	localparam logic [11:0] TURN_RATE_RST     = 12'd175;
	localparam logic [11:0] FORWARD_SPEED_RST = 12'd200;

	// quarter-wave polynomial coefficients, Q30
	localparam longint unsigned C1 = 64'd1686629713;
	localparam longint unsigned C3 = 64'd693598671;
	localparam longint unsigned C5 = 64'd85569278;
	localparam longint unsigned C7 = 64'd5026937;

	typedef enum logic [2:0] {
		REG_ANGLE_START   = 3'd0,
		REG_ANGLE_STEP    = 3'd1,
		REG_SECTOR_EDGE   = 3'd2,
		REG_HALF_WIDTH    = 3'd3,
		REG_ZONE_NEAR     = 3'd4,
		REG_ZONE_FAR      = 3'd5,
		REG_TURN_RATE     = 3'd6,
		REG_FORWARD_SPEED = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] angle_start;
		logic [15:0] angle_step;
		logic [15:0] sector_edge;
		logic [15:0] half_width;
		logic [15:0] zone_near;
		logic [15:0] zone_far;
		logic [11:0] turn_rate;
		logic [11:0] forward_speed;
	} cfg_t;

	// write of angle_start, which also restarts the scan angle
	typedef struct packed {
		logic        load;
		logic [15:0] value;
	} angle_load_t;

	// sine over a quarter turn, p in 0..16384, Q15 result capped at 32768
	function automatic logic [15:0] quarter_sine(input longint unsigned p);
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned q;
		x2 = (p * p) >> 14;
		t  = C5 - ((x2 * C7) >> 14);
		t  = C3 - ((x2 * t) >> 14);
		t  = C1 - ((x2 * t) >> 14);
		s  = (p * t) >> 14;
		q  = (s + 64'd16384) >> 15;
		if (q > 64'd32768)
			q = 64'd32768;
		return q[15:0];
	endfunction

	function automatic logic signed [16:0] table_sine(input logic [31:0] phase);
		logic [1:0]  quad;
		logic [13:0] p;
		logic [15:0] m;
		quad = phase[15:14];
		p    = phase[13:0];
		if (quad[0])
			m = quarter_sine(64'd16384 - 64'(p));
		else
			m = quarter_sine(64'(p));
		return quad[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	function automatic logic [15:0] sine_mag(input logic [31:0] phase);
		logic signed [16:0] s;
		logic signed [16:0] a;
		s = table_sine(phase);
		a = (s < 0) ? -s : s;
		return a[15:0];
	endfunction

endpackage

// ----- hdl/lfzc_regs.sv -----
// APB register file holding the block configuration.
module lfzc_regs import lfzc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output cfg_t                 cfg,
	output angle_load_t          angle_load
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign cfg    = cfg_q;

	assign angle_load.load  = wr_en && (idx == REG_ANGLE_START);
	assign angle_load.value = pwdata[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_start   <= ANGLE_START_RST;
			cfg_q.angle_step    <= ANGLE_STEP_RST;
			cfg_q.sector_edge   <= SECTOR_EDGE_RST;
			cfg_q.half_width    <= HALF_WIDTH_RST;
			cfg_q.zone_near     <= ZONE_NEAR_RST;
			cfg_q.zone_far      <= ZONE_FAR_RST;
			cfg_q.turn_rate     <= TURN_RATE_RST;
			cfg_q.forward_speed <= FORWARD_SPEED_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_ANGLE_START:   cfg_q.angle_start   <= pwdata[15:0];
				REG_ANGLE_STEP:    cfg_q.angle_step    <= pwdata[15:0];
				REG_SECTOR_EDGE:   cfg_q.sector_edge   <= pwdata[15:0];
				REG_HALF_WIDTH:    cfg_q.half_width    <= pwdata[15:0];
				REG_ZONE_NEAR:     cfg_q.zone_near     <= pwdata[15:0];
				REG_ZONE_FAR:      cfg_q.zone_far      <= pwdata[15:0];
				REG_TURN_RATE:     cfg_q.turn_rate     <= pwdata[11:0];
				REG_FORWARD_SPEED: cfg_q.forward_speed <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ANGLE_START:   prdata = {16'd0, cfg_q.angle_start};
			REG_ANGLE_STEP:    prdata = {16'd0, cfg_q.angle_step};
			REG_SECTOR_EDGE:   prdata = {16'd0, cfg_q.sector_edge};
			REG_HALF_WIDTH:    prdata = {16'd0, cfg_q.half_width};
			REG_ZONE_NEAR:     prdata = {16'd0, cfg_q.zone_near};
			REG_ZONE_FAR:      prdata = {16'd0, cfg_q.zone_far};
			REG_TURN_RATE:     prdata = {20'd0, cfg_q.turn_rate};
			REG_FORWARD_SPEED: prdata = {20'd0, cfg_q.forward_speed};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

// ----- hdl/lfzc_front.sv -----
// Front part: accepts samples, tracks the scan angle and classifies each sample.
module lfzc_front import lfzc_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
	parameter int RANGE_BITS       = RANGE_BITS_DEF,
	parameter int IW = $clog2(SINE_TABLE_DEPTH),
	parameter int RW = (RANGE_BITS < FIELD_BITS) ? RANGE_BITS : FIELD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  angle_load_t           angle_load,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FIELD_BITS-1:0] in_range,
	input  logic                  in_last,
	input  logic                  q_full,
	output logic                  q_push,
	output logic [RW-1:0]         q_range,
	output logic                  q_last,
	output logic                  q_sector,
	output logic [IW-1:0]         q_idx
);

	localparam int MW = 16 + $clog2(SINE_TABLE_DEPTH + 1);

	logic [15:0]   angle_q;
	logic [16:0]   upper_sum;
	logic [MW-1:0] idx_prod;
	logic          accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept;

	// sector wraps through angle zero
	assign upper_sum = {1'b0, angle_q} + {1'b0, cfg.sector_edge};
	assign q_sector  = (angle_q <= cfg.sector_edge) || upper_sum[16];

	assign idx_prod = MW'(angle_q) * MW'(SINE_TABLE_DEPTH);
	assign q_idx    = idx_prod[16 +: IW];
	assign q_range  = in_range[RW-1:0];
	assign q_last   = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= ANGLE_START_RST;
		end else if (angle_load.load) begin
			angle_q <= angle_load.value;
		end else if (accept) begin
			// restart the angle at the end of a scan
			angle_q <= in_last ? cfg.angle_start : angle_q + cfg.angle_step;
		end
	end

endmodule

// ----- hdl/lfzc_fifo.sv -----
// Short queue between the front and back parts.
module lfzc_fifo import lfzc_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- hdl/lfzc_back.sv -----
// Back part: sine lookup, projection, zone compare, hit latch and drive command.
module lfzc_back import lfzc_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
	parameter int RANGE_BITS       = RANGE_BITS_DEF,
	parameter int IW = $clog2(SINE_TABLE_DEPTH),
	parameter int RW = (RANGE_BITS < FIELD_BITS) ? RANGE_BITS : FIELD_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          q_valid,
	output logic          q_pop,
	input  logic [RW-1:0] q_range,
	input  logic          q_last,
	input  logic          q_sector,
	input  logic [IW-1:0] q_idx,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          out_obstacle,
	output logic [11:0]   out_linear,
	output logic [11:0]   out_angular
);

	localparam int XW = RW + 16;
	localparam int YW = RW + 18;
	localparam int CW = 48;

	logic [15:0]        sin_rom [SINE_TABLE_DEPTH];
	logic signed [16:0] cos_rom [SINE_TABLE_DEPTH];

	for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
		localparam logic [31:0] PH = 32'((i * 65536) / SINE_TABLE_DEPTH);
		assign sin_rom[i] = sine_mag(PH);
		assign cos_rom[i] = table_sine(PH + 32'd16384);
	end

	logic               advance;
	logic               v_s1, v_s2;
	logic               last_s1, last_s2;
	logic               sector_s1, sector_s2;
	logic [RW-1:0]      range_s1;
	logic [15:0]        sin_s1;
	logic signed [16:0] cos_s1;
	logic [XW-1:0]      xabs_s2;
	logic signed [YW-1:0] y_s2;
	logic               hit_q;
	logic               out_valid_q;
	logic               obstacle_q;
	logic [11:0]        linear_q;
	logic [11:0]        angular_q;

	logic signed [CW-1:0] y_ext;
	logic signed [CW-1:0] near_lim;
	logic signed [CW-1:0] far_lim;
	logic [CW-1:0]        x_ext;
	logic [CW-1:0]        lat_lim;
	logic                 hit_now;
	logic                 hit_total;

	// hold the whole back pipe while a result waits at the output
	assign advance = !(out_valid_q && !out_ready);
	assign q_pop   = advance && q_valid;

	always_ff @(posedge clk) begin
		if (advance) begin
			sin_s1    <= sin_rom[q_idx];
			cos_s1    <= cos_rom[q_idx];
			range_s1  <= q_range;
			last_s1   <= q_last;
			sector_s1 <= q_sector;
			xabs_s2   <= XW'(range_s1) * XW'(sin_s1);
			y_s2      <= $signed({1'b0, range_s1}) * cos_s1;
			last_s2   <= last_s1;
			sector_s2 <= sector_s1;
		end
	end

	assign x_ext    = CW'(xabs_s2);
	assign lat_lim  = {17'd0, cfg.half_width, 15'd0};
	assign y_ext    = CW'(y_s2);
	assign near_lim = $signed({17'd0, cfg.zone_near, 15'd0});
	assign far_lim  = $signed({17'd0, cfg.zone_far, 15'd0});

	assign hit_now   = sector_s2 && (x_ext <= lat_lim) &&
	                   (y_ext >= near_lim) && (y_ext <= far_lim);
	assign hit_total = hit_q || hit_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= q_valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2 && last_s2;
			if (v_s2)
				hit_q <= last_s2 ? 1'b0 : hit_total;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s2 && last_s2) begin
			obstacle_q <= hit_total;
			linear_q   <= hit_total ? 12'd0 : cfg.forward_speed;
			angular_q  <= hit_total ? cfg.turn_rate : 12'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_obstacle = obstacle_q;
	assign out_linear   = linear_q;
	assign out_angular  = angular_q;

endmodule

// ----- hdl/lidar_front_zone_obstacle_check_unit.sv -----
// Top level of the LiDAR front-zone obstacle check.
//
// Slave stream: one range sample per item, range_mm in s_axis_tdata, last sample of a
// scan on s_axis_tlast. Every sample advances the scan angle by angle_step, starting at
// angle_start. Samples inside the front sector are projected with the sine table and
// checked against the rectangle ahead; a hit is latched for the scan.
// Master stream: one item per scan, given for the last sample: obstacle flag on
// m_axis_tuser, linear and angular speed command in m_axis_tdata. The hit latch clears
// and the angle reloads from angle_start after that sample.
// Throughput: one sample per cycle while the receiver takes results, set by the table
// reads and the pair of multiplies in the back pipeline. A last sample passes the queue,
// table read, multiply, compare and output register before its result is valid. pready
// is always high. Configuration is to be written over APB only while the block is idle;
// the block does not enforce this. Reset restores register defaults, empties the queue
// and pipeline, clears the hit latch and sets the angle to angle_start. When the receiver
// stalls, the result holds on the master port and the back pipeline halts; the front
// keeps taking samples until the four-entry queue is full, then s_axis_tready drops.
module lidar_front_zone_obstacle_check_unit import lfzc_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
	parameter int RANGE_BITS       = RANGE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,   // [15:0] range_mm
	input  logic                 s_axis_tlast,   // last_sample
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [23:0]          m_axis_tdata,   // [11:0] linear_speed, [23:12] angular_speed
	output logic                 m_axis_tuser    // obstacle_found
);

	localparam int IW = $clog2(SINE_TABLE_DEPTH);
	localparam int RW = (RANGE_BITS < FIELD_BITS) ? RANGE_BITS : FIELD_BITS;
	localparam int QW = RW + 2 + IW;

	cfg_t          cfg;
	angle_load_t   angle_load;
	logic          q_full, q_push, q_valid, q_pop;
	logic [RW-1:0] f_range, b_range;
	logic          f_last, f_sector, b_last, b_sector;
	logic [IW-1:0] f_idx, b_idx;
	logic [QW-1:0] q_wr, q_rd;
	logic [11:0]   linear, angular;

	lfzc_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cfg        (cfg),
		.angle_load (angle_load)
	);

	lfzc_front #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.RANGE_BITS       (RANGE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.angle_load (angle_load),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_range   (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_range    (f_range),
		.q_last     (f_last),
		.q_sector   (f_sector),
		.q_idx      (f_idx)
	);

	assign q_wr = {f_idx, f_sector, f_last, f_range};
	assign {b_idx, b_sector, b_last, b_range} = q_rd;

	lfzc_fifo #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.rd_data (q_rd)
	);

	lfzc_back #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.RANGE_BITS       (RANGE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_range      (b_range),
		.q_last       (b_last),
		.q_sector     (b_sector),
		.q_idx        (b_idx),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_obstacle (m_axis_tuser),
		.out_linear   (linear),
		.out_angular  (angular)
	);

	assign m_axis_tdata = {angular, linear};

endmodule

// ----- test/lfzc_drive_checker.sv -----
// Scoreboard for the front-zone obstacle check: mirrors registers and scans, checks drive commands.
module lfzc_drive_checker import lfzc_pkg::*; #(
	parameter int TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
	parameter int RANGE_WIDTH = RANGE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,   // [15:0] range_mm
	input  logic                 s_axis_tlast,   // last_sample
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [23:0]          m_axis_tdata,   // [11:0] linear_speed, [23:12] angular_speed
	input  logic                 m_axis_tuser,   // obstacle_found
	output int unsigned          mismatches,
	output int unsigned          commands_left,
	output int unsigned          scans_closed,
	output int unsigned          obstacle_scans
);

	typedef struct packed {
		logic        obstacle;
		logic [11:0] linear;
		logic [11:0] angular;
	} drive_cmd_t;

	cfg_t        regs;
	logic [15:0] scan_angle;
	logic        hit_seen;
	drive_cmd_t  expected_cmds[$];
	drive_cmd_t  cmd;
	longint      sample_range;
	longint      lateral;
	longint      forward;
	longint unsigned tab_idx;
	logic [15:0] phase;
	int          sin_q15;
	int          cos_q15;

	int unsigned n_fail      = 0;
	int unsigned n_left      = 0;
	int unsigned n_scans     = 0;
	int unsigned n_obstacles = 0;

	assign mismatches     = n_fail;
	assign commands_left  = n_left;
	assign scans_closed   = n_scans;
	assign obstacle_scans = n_obstacles;

	task automatic report_mismatch(input string msg);
		n_fail++;
		$display("[%0t] drive command %0d: %s", $time, n_scans, msg);
	endtask

	// Q15 sine over the first quarter turn, p in 0..16384, odd polynomial in Q30
	function automatic int unsigned quarter_wave(input int unsigned p);
		longint unsigned u;
		longint unsigned u2;
		longint unsigned acc;
		u   = p;
		u2  = (u * u) >> 14;
		acc = C5 - ((u2 * C7) >> 14);
		acc = C3 - ((u2 * acc) >> 14);
		acc = C1 - ((u2 * acc) >> 14);
		acc = (((u * acc) >> 14) + 64'd16384) >> 15;
		return (acc > 64'd32768) ? 32'd32768 : 32'(acc);
	endfunction

	function automatic int signed_sine(input logic [15:0] ph);
		int unsigned m;
		m = ph[14] ? quarter_wave(32'd16384 - ph[13:0]) : quarter_wave(ph[13:0]);
		return ph[15] ? -int'(m) : int'(m);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = {ANGLE_START_RST, ANGLE_STEP_RST, SECTOR_EDGE_RST, HALF_WIDTH_RST,
				ZONE_NEAR_RST, ZONE_FAR_RST, TURN_RATE_RST, FORWARD_SPEED_RST};
			scan_angle = ANGLE_START_RST;
			hit_seen   = 1'b0;
			expected_cmds.delete();
			n_left = 0;
		end else begin
			// the result leaving now is older than any sample taken at this edge
			if (m_axis_tvalid && m_axis_tready) begin
				n_scans++;
				if (expected_cmds.size() == 0) begin
					report_mismatch($sformatf("unexpected, tdata %h tuser %b",
						m_axis_tdata, m_axis_tuser));
				end else begin
					cmd = expected_cmds.pop_front();
					if (m_axis_tuser !== cmd.obstacle)
						report_mismatch($sformatf("obstacle_found %b, expected %b",
							m_axis_tuser, cmd.obstacle));
					if (m_axis_tdata[11:0] !== cmd.linear)
						report_mismatch($sformatf("linear_speed %0d, expected %0d",
							m_axis_tdata[11:0], cmd.linear));
					if (m_axis_tdata[23:12] !== cmd.angular)
						report_mismatch($sformatf("angular_speed %0d, expected %0d",
							m_axis_tdata[23:12], cmd.angular));
					if (cmd.obstacle)
						n_obstacles++;
				end
			end

			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_ANGLE_START: begin
						regs.angle_start = pwdata[15:0];
						scan_angle       = pwdata[15:0];
					end
					REG_ANGLE_STEP:    regs.angle_step    = pwdata[15:0];
					REG_SECTOR_EDGE:   regs.sector_edge   = pwdata[15:0];
					REG_HALF_WIDTH:    regs.half_width    = pwdata[15:0];
					REG_ZONE_NEAR:     regs.zone_near     = pwdata[15:0];
					REG_ZONE_FAR:      regs.zone_far      = pwdata[15:0];
					REG_TURN_RATE:     regs.turn_rate     = pwdata[11:0];
					REG_FORWARD_SPEED: regs.forward_speed = pwdata[11:0];
					default: ;
				endcase
			end

			if (s_axis_tvalid && s_axis_tready) begin
				sample_range = longint'(s_axis_tdata) & ((64'sd1 <<< RANGE_WIDTH) - 64'sd1);
				if (scan_angle <= regs.sector_edge ||
						32'(scan_angle) + 32'(regs.sector_edge) >= 32'd65536) begin
					// quantize the angle to a table entry, then project the range
					tab_idx = (64'(scan_angle) * 64'(TABLE_DEPTH)) >> 16;
					phase   = 16'((tab_idx * 64'd65536) / 64'(TABLE_DEPTH));
					sin_q15 = signed_sine(phase);
					cos_q15 = signed_sine(phase + 16'd16384);
					lateral = sample_range * longint'((sin_q15 < 0) ? -sin_q15 : sin_q15);
					forward = sample_range * longint'(cos_q15);
					if (lateral <= (longint'(regs.half_width) <<< 15) &&
							forward >= (longint'(regs.zone_near) <<< 15) &&
							forward <= (longint'(regs.zone_far) <<< 15))
						hit_seen = 1'b1;
				end
				scan_angle = scan_angle + regs.angle_step;
				if (s_axis_tlast) begin
					cmd.obstacle = hit_seen;
					cmd.linear   = hit_seen ? 12'd0 : regs.forward_speed;
					cmd.angular  = hit_seen ? regs.turn_rate : 12'd0;
					expected_cmds.push_back(cmd);
					hit_seen   = 1'b0;
					scan_angle = regs.angle_start;
				end
			end

			n_left = expected_cmds.size();
		end
	end

endmodule

// ----- test/testbench.sv -----
// Top of the front-zone obstacle check testbench: clock, reset, stimulus and verdict.
module testbench;
	import lfzc_pkg::*;

	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_SAMPLES = 161;
	localparam int DRAIN_CYCLES  = 10;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata;   // [15:0] range_mm
	logic                 s_axis_tlast;   // last_sample
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [23:0]          m_axis_tdata;   // [11:0] linear_speed, [23:12] angular_speed
	logic                 m_axis_tuser;   // obstacle_found

	int unsigned fail_total;
	int unsigned cmds_pending;
	int unsigned scans_done;
	int unsigned obstacle_total;

	int unsigned samples_sent = 0;
	int unsigned burst_left   = 0;
	logic [15:0] setting [8];

	rx_mode_t    rx_mode      = RX_OPEN;
	int unsigned rx_mode_left = 0;
	int unsigned rx_tick      = 0;

	lidar_front_zone_obstacle_check_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	lfzc_drive_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.mismatches     (fail_total),
		.commands_left  (cmds_pending),
		.scans_closed   (scans_done),
		.obstacle_scans (obstacle_total)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver stall pattern, switching to a random mode when the current one runs out
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      = rx_mode_t'($urandom_range(0, 3));
			rx_mode_left = $urandom_range(50, 300);
		end
		rx_mode_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN:   m_axis_tready <= 1'b1;
			RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default:   m_axis_tready <= (rx_tick % 16) >= 11;
		endcase
	end

	initial begin
		#8000000;
		$display("** lidar_front_zone_obstacle_check_unit: FAILED **");
		$finish;
	end

	task automatic program_reg(input reg_idx_t r, input int unsigned v);
		if (r == REG_TURN_RATE || r == REG_FORWARD_SPEED)
			v &= 32'hFFF;
		else
			v &= 32'hFFFF;
		setting[r] = 16'(v);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {r, 2'b00};
		pwdata  = v;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// call at a falling edge; leaves tvalid high after the item is taken
	task automatic send_sample(input logic [15:0] range_mm, input logic closes);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_axis_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = range_mm;
		s_axis_tlast  = closes;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		samples_sent++;
		@(negedge clk);
	endtask

	// hold off until every command is out and trailing samples have left the pipe
	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		while (cmds_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// ranges mostly at the scale of the rectangle, with some full-scale noise
	function automatic logic [15:0] pick_range();
		int unsigned span;
		span = (setting[REG_ZONE_NEAR] > setting[REG_ZONE_FAR]) ?
			setting[REG_ZONE_NEAR] : setting[REG_ZONE_FAR];
		span = span + setting[REG_HALF_WIDTH] / 2 + 16;
		if (span > 65535)
			span = 65535;
		case ($urandom_range(0, 9))
			0:       return 16'($urandom());
			1:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(0, span));
		endcase
	endfunction

	task automatic configure_phase(input int p);
		int unsigned v;
		reg_idx_t    r;
		for (int i = 0; i < 8; i++) begin
			r = reg_idx_t'(i);
			if (p == 1) begin
				v = 32'hFFFF;
			end else if (p == 2) begin
				v = 0;
			end else if (p == 0 || $urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 7) == 0) begin
					v = ($urandom_range(0, 1) != 0) ? 32'hFFFF : 0;
				end else begin
					case (r)
						REG_ANGLE_STEP: v = ($urandom_range(0, 1) != 0) ?
							$urandom_range(1, 600) : $urandom_range(0, 65535);
						REG_SECTOR_EDGE: v = $urandom_range(0, 32768);
						REG_HALF_WIDTH, REG_ZONE_NEAR: v = $urandom_range(0, 1500);
						REG_ZONE_FAR: begin
							v = setting[REG_ZONE_NEAR] + $urandom_range(0, 1500);
							if (v > 65535)
								v = 65535;
						end
						default: v = $urandom_range(0, 65535);
					endcase
				end
			end else begin
				continue;
			end
			program_reg(r, v);
		end
		// widest legal sector with an inverted forward band
		if (p == 3) begin
			program_reg(REG_SECTOR_EDGE, 32768);
			program_reg(REG_ZONE_NEAR, 900);
			program_reg(REG_ZONE_FAR, 300);
		end
	endtask

	initial begin
		int   left;
		int   len;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		setting[REG_ANGLE_START]   = ANGLE_START_RST;
		setting[REG_ANGLE_STEP]    = ANGLE_STEP_RST;
		setting[REG_SECTOR_EDGE]   = SECTOR_EDGE_RST;
		setting[REG_HALF_WIDTH]    = HALF_WIDTH_RST;
		setting[REG_ZONE_NEAR]     = ZONE_NEAR_RST;
		setting[REG_ZONE_FAR]      = ZONE_FAR_RST;
		setting[REG_TURN_RATE]     = 16'(TURN_RATE_RST);
		setting[REG_FORWARD_SPEED] = 16'(FORWARD_SPEED_RST);
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: mostly single-sample scans around the forward band edges
		send_sample(16'd0, 1'b1);
		send_sample(16'd200, 1'b1);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'd141, 1'b1);
		send_sample(16'd341, 1'b1);
		send_sample(16'd140, 1'b1);
		send_sample(16'd342, 1'b1);
		send_sample(16'd300, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'd250, 1'b1);
		// hit only on the closing sample
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'd0, 1'b0);
		send_sample(16'd200, 1'b1);
		send_sample(16'd5000, 1'b0);
		send_sample(16'd5000, 1'b0);
		send_sample(16'd5000, 1'b1);
		// leave a hit latched in an open scan across the angle reload
		send_sample(16'd200, 1'b0);
		wait_idle();
		program_reg(REG_ANGLE_START, 0);
		program_reg(REG_SECTOR_EDGE, 0);
		program_reg(REG_ANGLE_STEP, 1);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'd141, 1'b1);
		send_sample(16'd140, 1'b1);
		send_sample(16'd0, 1'b1);
		// second sample sits one unit off the zero-width sector
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'd200, 1'b1);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			configure_phase(p);
			left = PHASE_SAMPLES;
			while (left > 0) begin
				if ($urandom_range(0, 6) == 0) begin
					send_sample(16'($urandom()), $urandom_range(0, 7) == 0);
					left--;
				end else begin
					len = ($urandom_range(0, 3) == 0) ?
						$urandom_range(1, 3) : $urandom_range(4, 40);
					for (int k = 0; k < len && left > 0; k++) begin
						send_sample(pick_range(), k == len - 1);
						left--;
					end
				end
			end
		end
		wait_idle();

		$display("Sent %0d range samples over %0d register settings after the directed set;",
			samples_sent, RANDOM_PHASES);
		$display("%0d scans closed, %0d of them reported an obstacle ahead.",
			scans_done, obstacle_total);
		if (fail_total == 0)
			$display("** lidar_front_zone_obstacle_check_unit: PASSED **");
		else
			$display("** lidar_front_zone_obstacle_check_unit: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/lfzc_pkg.sv
hdl/lfzc_regs.sv
hdl/lfzc_front.sv
hdl/lfzc_fifo.sv
hdl/lfzc_back.sv
hdl/lidar_front_zone_obstacle_check_unit.sv
test/lfzc_drive_checker.sv
test/testbench.sv
